/* hw/rtl/dll_pkg.sv */
package dll_pkg;

    localparam int POOL_NODES_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int KIND_WIDTH      = 4;

    typedef enum logic [3:0] {
        KIND_CLEAR      = 4'd0,
        KIND_INS_FIRST  = 4'd1,
        KIND_INS_LAST   = 4'd2,
        KIND_GO_FIRST   = 4'd3,
        KIND_GO_LAST    = 4'd4,
        KIND_DEL_FIRST  = 4'd5,
        KIND_DEL_LAST   = 4'd6,
        KIND_DEL_AFTER  = 4'd7,
        KIND_DEL_BEFORE = 4'd8,
        KIND_INS_AFTER  = 4'd9,
        KIND_INS_BEFORE = 4'd10,
        KIND_SET_VALUE  = 4'd11,
        KIND_NEXT       = 4'd12,
        KIND_PREV       = 4'd13
    } kind_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_SET  = 2'd3
    } cell_op_t;

    // read-side selects broadcast to every cell
    typedef struct packed {
        logic nonempty;
        logic cur_active;
    } cell_sel_t;

endpackage

/* hw/rtl/dll_cell.sv */
module dll_cell #(
    parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEF,
    parameter int PW          = 6,
    parameter int IDX         = 0
) (
    input  logic                   clk,
    input  dll_pkg::cell_op_t      op,
    input  logic [PW-1:0]          pos,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [VALUE_WIDTH-1:0] left_data,
    input  logic [VALUE_WIDTH-1:0] right_data,
    input  dll_pkg::cell_sel_t     sel,
    input  logic [PW-1:0]          last_pos,
    input  logic [PW-1:0]          cur_pos,
    output logic [VALUE_WIDTH-1:0] data,
    output logic [VALUE_WIDTH-1:0] first_part,
    output logic [VALUE_WIDTH-1:0] last_part,
    output logic [VALUE_WIDTH-1:0] cur_part
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [VALUE_WIDTH-1:0] data_reg;
    logic [VALUE_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            dll_pkg::CELL_INS:
            begin
                if (MY_IDX > pos)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == pos)
                begin
                    data_next = value;
                end
            end
            dll_pkg::CELL_DEL:
            begin
                if (MY_IDX >= pos)
                begin
                    data_next = right_data;
                end
            end
            dll_pkg::CELL_SET:
            begin
                if (MY_IDX == pos)
                begin
                    data_next = value;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data       = data_reg;
    assign first_part = (sel.nonempty && IDX == 0) ? data_reg : '0;
    assign last_part  = (sel.nonempty && MY_IDX == last_pos) ? data_reg : '0;
    assign cur_part   = (sel.cur_active && MY_IDX == cur_pos) ? data_reg : '0;

endmodule

/* hw/rtl/doubly_linked_list_with_cursor.sv */
// An accepted input beat updates the cell row and the list state; in ST_WORK the row is read
// into the output registers, and in ST_OUT the result beat is offered. A new operation is taken
// only while idle or while the pending result beat is being taken by the result side.
// Reset (rst_n low, asynchronous): list empty, cursor inactive, no result pending.
// Cell contents are not reset; a cell is read only after it was written.
module doubly_linked_list_with_cursor #(
    parameter int POOL_NODES  = dll_pkg::POOL_NODES_DEF,
    parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // kind, value
    input  logic [((dll_pkg::KIND_WIDTH + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // first_value, last_value, cursor_value, cursor_active, list_empty, pool_error
    output logic [((3 * VALUE_WIDTH + 3 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int IN_BITS  = dll_pkg::KIND_WIDTH + VALUE_WIDTH;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 3 * VALUE_WIDTH + 3;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int PW       = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int CW       = $clog2(POOL_NODES + 1);
    localparam logic [CW-1:0] FULL = CW'(POOL_NODES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WORK = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] cpos_reg, cpos_next;
    logic          act_reg, act_next;
    logic          err_reg, err_next;

    logic [VALUE_WIDTH-1:0] first_reg, last_reg, cur_reg;
    logic                   oact_reg, oempty_reg, oerr_reg;

    dll_pkg::kind_t         kind;
    logic [VALUE_WIDTH-1:0] value;
    logic                   in_acc;
    dll_pkg::cell_op_t      op;
    logic [PW-1:0]          pos;
    logic [PW-1:0]          last_pos;
    logic                   nonempty, full;
    dll_pkg::cell_sel_t     sel;

    assign kind     = dll_pkg::kind_t'(s_tdata[dll_pkg::KIND_WIDTH-1:0]);
    assign value    = s_tdata[dll_pkg::KIND_WIDTH +: VALUE_WIDTH];
    assign s_tready = (state_reg == ST_IDLE) || (state_reg == ST_OUT && m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign nonempty = (cnt_reg != '0);
    assign full     = (cnt_reg == FULL);
    assign last_pos = PW'(cnt_reg - CW'(1));

    always_comb
    begin
        op        = dll_pkg::CELL_HOLD;
        pos       = '0;
        cnt_next  = cnt_reg;
        cpos_next = cpos_reg;
        act_next  = act_reg;
        err_next  = err_reg;
        if (in_acc)
        begin
            err_next = 1'b0;
            case (kind)
                dll_pkg::KIND_CLEAR:
                begin
                    cnt_next = '0;
                    act_next = 1'b0;
                end
                dll_pkg::KIND_INS_FIRST, dll_pkg::KIND_INS_LAST,
                dll_pkg::KIND_INS_AFTER, dll_pkg::KIND_INS_BEFORE:
                begin
                    if (kind == dll_pkg::KIND_INS_FIRST)
                    begin
                        pos = '0;
                    end
                    else if (kind == dll_pkg::KIND_INS_LAST)
                    begin
                        pos = PW'(cnt_reg);
                    end
                    else if (kind == dll_pkg::KIND_INS_AFTER)
                    begin
                        pos = cpos_reg + PW'(1);
                    end
                    else
                    begin
                        pos = cpos_reg;
                    end
                    if ((kind == dll_pkg::KIND_INS_AFTER || kind == dll_pkg::KIND_INS_BEFORE)
                        && !act_reg)
                    begin
                        op = dll_pkg::CELL_HOLD;
                    end
                    else if (full)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        op       = dll_pkg::CELL_INS;
                        cnt_next = cnt_reg + CW'(1);
                        if (act_reg && cpos_reg >= pos)
                        begin
                            cpos_next = cpos_reg + PW'(1);
                        end
                    end
                end
                dll_pkg::KIND_GO_FIRST:
                begin
                    act_next  = nonempty;
                    cpos_next = '0;
                end
                dll_pkg::KIND_GO_LAST:
                begin
                    act_next  = nonempty;
                    cpos_next = last_pos;
                end
                dll_pkg::KIND_DEL_FIRST:
                begin
                    if (nonempty)
                    begin
                        op       = dll_pkg::CELL_DEL;
                        pos      = '0;
                        cnt_next = cnt_reg - CW'(1);
                        if (act_reg)
                        begin
                            if (cpos_reg == '0)
                            begin
                                act_next = 1'b0;
                            end
                            else
                            begin
                                cpos_next = cpos_reg - PW'(1);
                            end
                        end
                    end
                end
                dll_pkg::KIND_DEL_LAST:
                begin
                    if (nonempty)
                    begin
                        op       = dll_pkg::CELL_DEL;
                        pos      = last_pos;
                        cnt_next = cnt_reg - CW'(1);
                        if (act_reg && cpos_reg == last_pos)
                        begin
                            act_next = 1'b0;
                        end
                    end
                end
                dll_pkg::KIND_DEL_AFTER:
                begin
                    if (act_reg && cpos_reg != last_pos)
                    begin
                        op       = dll_pkg::CELL_DEL;
                        pos      = cpos_reg + PW'(1);
                        cnt_next = cnt_reg - CW'(1);
                    end
                end
                dll_pkg::KIND_DEL_BEFORE:
                begin
                    if (act_reg && cpos_reg != '0)
                    begin
                        op        = dll_pkg::CELL_DEL;
                        pos       = cpos_reg - PW'(1);
                        cnt_next  = cnt_reg - CW'(1);
                        cpos_next = cpos_reg - PW'(1);
                    end
                end
                dll_pkg::KIND_SET_VALUE:
                begin
                    if (act_reg)
                    begin
                        op  = dll_pkg::CELL_SET;
                        pos = cpos_reg;
                    end
                end
                dll_pkg::KIND_NEXT:
                begin
                    if (act_reg)
                    begin
                        if (cpos_reg == last_pos)
                        begin
                            act_next = 1'b0;
                        end
                        else
                        begin
                            cpos_next = cpos_reg + PW'(1);
                        end
                    end
                end
                dll_pkg::KIND_PREV:
                begin
                    if (act_reg)
                    begin
                        if (cpos_reg == '0)
                        begin
                            act_next = 1'b0;
                        end
                        else
                        begin
                            cpos_next = cpos_reg - PW'(1);
                        end
                    end
                end
                default:
                begin
                    op = dll_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    // cell row
    logic [VALUE_WIDTH-1:0] cell_data  [POOL_NODES];
    logic [VALUE_WIDTH-1:0] first_part [POOL_NODES];
    logic [VALUE_WIDTH-1:0] last_part  [POOL_NODES];
    logic [VALUE_WIDTH-1:0] cur_part   [POOL_NODES];

    assign sel.nonempty   = nonempty;
    assign sel.cur_active = act_reg;

    for (genvar i = 0; i < POOL_NODES; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_d, right_d;
        if (i == 0)
        begin : g_l0
            assign left_d = '0;
        end
        else
        begin : g_ln
            assign left_d = cell_data[i-1];
        end
        if (i == POOL_NODES - 1)
        begin : g_r0
            assign right_d = '0;
        end
        else
        begin : g_rn
            assign right_d = cell_data[i+1];
        end
        dll_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .PW          (PW),
            .IDX         (i)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .pos        (pos),
            .value      (value),
            .left_data  (left_d),
            .right_data (right_d),
            .sel        (sel),
            .last_pos   (last_pos),
            .cur_pos    (cpos_reg),
            .data       (cell_data[i]),
            .first_part (first_part[i]),
            .last_part  (last_part[i]),
            .cur_part   (cur_part[i])
        );
    end

    logic [VALUE_WIDTH-1:0] first_or, last_or, cur_or;

    always_comb
    begin
        first_or = '0;
        last_or  = '0;
        cur_or   = '0;
        for (int i = 0; i < POOL_NODES; i++)
        begin
            first_or = first_or | first_part[i];
            last_or  = last_or | last_part[i];
            cur_or   = cur_or | cur_part[i];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (in_acc)
                begin
                    state_next = ST_WORK;
                end
                else if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            cpos_reg  <= '0;
            act_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cpos_reg  <= cpos_next;
            act_reg   <= act_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WORK)
        begin
            first_reg  <= first_or;
            last_reg   <= last_or;
            cur_reg    <= cur_or;
            oact_reg   <= act_reg;
            oempty_reg <= !nonempty;
            oerr_reg   <= err_reg;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = OUT_W'({oerr_reg, oempty_reg, oact_reg, cur_reg, last_reg, first_reg});

endmodule

/* hw/rtl/dll_checker.sv */
module dll_assert_checker #(
    parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEF,
    parameter int OUT_W       = 104
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam int ACT_BIT   = 3 * VALUE_WIDTH;
    localparam int EMPTY_BIT = 3 * VALUE_WIDTH + 1;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result beat one cycle after input beat");

    a_out_after_two: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("no result beat two cycles after input beat");

    a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[EMPTY_BIT] |->
            !m_tdata[ACT_BIT] && m_tdata[2*VALUE_WIDTH-1:0] == '0)
        else $error("empty list reports values or an active cursor");

endmodule

bind doubly_linked_list_with_cursor dll_assert_checker #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .OUT_W       (OUT_W)
) u_dll_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/dll_checker.sv */
`timescale 1ns / 100ps

module dll_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [39:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    output int           fail_count,
    output int           pending
);
    import dll_pkg::*;

    localparam logic [6:0] NIL = 7'd64;

    typedef struct {
        logic [31:0] first_value;
        logic [31:0] last_value;
        logic [31:0] cursor_value;
        logic        cursor_active;
        logic        list_empty;
        logic        pool_error;
    } list_status_t;

    logic [31:0] node_val [64];
    logic [6:0]  node_next [64];
    logic [6:0]  node_prev [64];
    logic [6:0]  head_idx, tail_idx, cur_idx, free_idx;
    logic [6:0]  fresh_count;

    list_status_t status_q[$];

    function automatic logic live(logic [6:0] i);
        return !i[6];
    endfunction

    // returns 0 when no node is free
    task automatic link_between(input logic [6:0] a, input logic [6:0] b,
                                input logic [31:0] v, output logic ok);
        logic [6:0] n;
        ok = 1'b1;
        if (live(free_idx)) begin
            n = free_idx;
            free_idx = node_next[n];
        end else if (fresh_count < 7'd64) begin
            n = fresh_count;
            fresh_count++;
        end else begin
            ok = 1'b0;
            return;
        end
        node_val[n]  = v;
        node_prev[n] = a;
        node_next[n] = b;
        if (live(a)) node_next[a] = n; else head_idx = n;
        if (live(b)) node_prev[b] = n; else tail_idx = n;
    endtask

    task automatic unlink_node(input logic [6:0] n);
        logic [6:0] a, b;
        a = node_prev[n];
        b = node_next[n];
        if (cur_idx == n) cur_idx = NIL;
        if (live(a)) node_next[a] = b; else head_idx = b;
        if (live(b)) node_prev[b] = a; else tail_idx = a;
        node_next[n] = free_idx;
        free_idx = n;
    endtask

    task automatic apply_op(input logic [3:0] kind, input logic [31:0] v,
                            output list_status_t r);
        logic ok, act;
        ok  = 1'b1;
        act = live(cur_idx);
        case (kind)
            KIND_CLEAR: begin
                head_idx = NIL; tail_idx = NIL; cur_idx = NIL;
                free_idx = NIL; fresh_count = '0;
            end
            KIND_INS_FIRST:  link_between(NIL, head_idx, v, ok);
            KIND_INS_LAST:   link_between(tail_idx, NIL, v, ok);
            KIND_GO_FIRST:   cur_idx = head_idx;
            KIND_GO_LAST:    cur_idx = tail_idx;
            KIND_DEL_FIRST:  if (live(head_idx)) unlink_node(head_idx);
            KIND_DEL_LAST:   if (live(tail_idx)) unlink_node(tail_idx);
            KIND_DEL_AFTER:
                if (act && live(node_next[cur_idx])) unlink_node(node_next[cur_idx]);
            KIND_DEL_BEFORE:
                if (act && live(node_prev[cur_idx])) unlink_node(node_prev[cur_idx]);
            KIND_INS_AFTER:
                if (act) link_between(cur_idx, node_next[cur_idx], v, ok);
            KIND_INS_BEFORE:
                if (act) link_between(node_prev[cur_idx], cur_idx, v, ok);
            KIND_SET_VALUE:  if (act) node_val[cur_idx] = v;
            KIND_NEXT:       if (act) cur_idx = node_next[cur_idx];
            KIND_PREV:       if (act) cur_idx = node_prev[cur_idx];
            default: ;
        endcase
        r.first_value   = live(head_idx) ? node_val[head_idx] : '0;
        r.last_value    = live(tail_idx) ? node_val[tail_idx] : '0;
        r.cursor_value  = live(cur_idx) ? node_val[cur_idx] : '0;
        r.cursor_active = live(cur_idx);
        r.list_empty    = !live(head_idx);
        r.pool_error    = !ok;
    endtask

    task automatic report(input string field, input logic [31:0] got,
                          input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $realtime, field, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count  = 0;
        pending     = 0;
        head_idx    = NIL;
        tail_idx    = NIL;
        cur_idx     = NIL;
        free_idx    = NIL;
        fresh_count = '0;
        for (int i = 0; i < 64; i++) begin
            node_val[i]  = '0;
            node_next[i] = NIL;
            node_prev[i] = NIL;
        end
    end

    always @(posedge clk) begin
        list_status_t exp_s, got_s;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                apply_op(s_tdata[3:0], s_tdata[35:4], exp_s);
                status_q.push_back(exp_s);
            end
            if (m_tvalid && m_tready) begin
                got_s.first_value   = m_tdata[31:0];
                got_s.last_value    = m_tdata[63:32];
                got_s.cursor_value  = m_tdata[95:64];
                got_s.cursor_active = m_tdata[96];
                got_s.list_empty    = m_tdata[97];
                got_s.pool_error    = m_tdata[98];
                if (status_q.size() == 0) begin
                    $display("%0t result beat with nothing outstanding", $realtime);
                    fail_count++;
                end else begin
                    exp_s = status_q.pop_front();
                    if (!got_s.list_empty && got_s.first_value !== exp_s.first_value)
                        report("first_value", got_s.first_value, exp_s.first_value);
                    if (!got_s.list_empty && got_s.last_value !== exp_s.last_value)
                        report("last_value", got_s.last_value, exp_s.last_value);
                    if (got_s.cursor_active && got_s.cursor_value !== exp_s.cursor_value)
                        report("cursor_value", got_s.cursor_value, exp_s.cursor_value);
                    if (got_s.cursor_active !== exp_s.cursor_active)
                        report("cursor_active", got_s.cursor_active, exp_s.cursor_active);
                    if (got_s.list_empty !== exp_s.list_empty)
                        report("list_empty", got_s.list_empty, exp_s.list_empty);
                    if (got_s.pool_error !== exp_s.pool_error)
                        report("pool_error", got_s.pool_error, exp_s.pool_error);
                end
            end
            pending = status_q.size();
        end
    end

endmodule

/* tb/tb_doubly_linked_list_with_cursor.sv */
`timescale 1ns / 100ps

module tb_doubly_linked_list_with_cursor;
    import dll_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  s_tdata;   // kind[3:0], value[35:4], zero pad
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;   // first, last, cursor value, active, empty, pool error
    int           fail_count;
    int           pending;
    bit           tx_idle;
    bit           rx_idle;
    bit           long_hold;

    doubly_linked_list_with_cursor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dll_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    // mode 0 grows the list, 1 shrinks it, 2 mixes everything
    function automatic logic [3:0] pick_kind(int mode);
        int r;
        r = $urandom_range(0, 199);
        if (r == 0) return KIND_CLEAR;
        if (r < 3) return 4'($urandom_range(14, 15));
        if (r < 35) return ($urandom_range(0, 1)) ? KIND_GO_FIRST : KIND_GO_LAST;
        if (r < 150) begin
            if (mode == 0)
                case ($urandom_range(0, 3))
                    0: return KIND_INS_FIRST;
                    1: return KIND_INS_LAST;
                    2: return KIND_INS_AFTER;
                    default: return KIND_INS_BEFORE;
                endcase
            if (mode == 1)
                case ($urandom_range(0, 3))
                    0: return KIND_DEL_FIRST;
                    1: return KIND_DEL_LAST;
                    2: return KIND_DEL_AFTER;
                    default: return KIND_DEL_BEFORE;
                endcase
        end
        return 4'($urandom_range(1, 13));
    endfunction

    task automatic send(input logic [3:0] kind, input logic [31:0] v);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, v, kind};
        do @(posedge clk); while (!s_tready);
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side
    initial
    begin
        int w;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = rx_idle ? $urandom_range(0, 11) : 0;
            if (long_hold)
            begin
                w = 300;
                long_hold = 0;
            end
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        int mode;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        rst_n     = 1'b0;
        tx_idle   = 1;
        rx_idle   = 1;
        long_hold = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cursor and delete ops on an empty list, then basic walks
        send(KIND_CLEAR, 32'h0);
        send(KIND_DEL_FIRST, 32'h0);
        send(KIND_DEL_LAST, 32'h0);
        for (int k = KIND_DEL_AFTER; k <= KIND_PREV; k++)
            send(4'(k), 32'h1234_5678);
        send(KIND_INS_FIRST, 32'h8000_0000);
        send(KIND_INS_LAST, 32'h7fff_ffff);
        send(KIND_GO_FIRST, 32'h0);
        send(KIND_PREV, 32'h0);            // steps off the front
        send(KIND_GO_LAST, 32'h0);
        send(KIND_NEXT, 32'h0);            // steps off the back
        send(KIND_GO_FIRST, 32'h0);
        send(KIND_DEL_BEFORE, 32'h0);      // nothing before the first node
        send(KIND_INS_AFTER, 32'hffff_ffff);
        send(KIND_INS_BEFORE, 32'h0000_0001);
        send(KIND_SET_VALUE, 32'hdead_beef);
        send(KIND_DEL_AFTER, 32'h0);
        send(KIND_DEL_FIRST, 32'h0);       // the cursor stays on its node
        send(4'd14, 32'h0);
        send(4'd15, 32'hffff_ffff);
        send(KIND_GO_LAST, 32'h0);
        send(KIND_DEL_LAST, 32'h0);        // drops the cursor

        mode = 0;
        for (int i = 0; i < 1700; i++)
        begin
            if (i % 120 == 0)
            begin
                mode = (i < 240) ? 0 : $urandom_range(0, 2);
                tx_idle = $urandom_range(0, 3) != 0;
                rx_idle = $urandom_range(0, 3) != 0;
            end
            if (i == 400) long_hold = 1;
            if (i == 900)
            begin
                s_tvalid <= 1'b0;
                do @(negedge clk); while (pending != 0);
                @(posedge clk);
            end
            send(pick_kind(mode), pick_value());
        end

        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
